### hw/rtl/dual_tacho_period_speed_macros.svh
// Assertion macros shared by the dual tachometer speed meter RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DUAL_TACHO_PERIOD_SPEED_MACROS_SVH
`define DUAL_TACHO_PERIOD_SPEED_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DTPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtps check failed");

// Next-cycle implication, checked out of reset.
`define DTPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtps check failed");

`endif

### hw/rtl/dtps_pkg.sv
// Package for the dual tachometer speed meter: widths, reset values,
// register indexes and the job record passed from front to back. No dependencies.
`timescale 1ns / 1ps

package dtps_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int COUNT_BITS    = 13;
  localparam int SPEED_BITS    = 20;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = SPEED_BITS;
  localparam int JOB_DEPTH     = 2;
  localparam int PTR_BITS      = $clog2(JOB_DEPTH);
  localparam int LEVEL_BITS    = $clog2(JOB_DEPTH + 1);
  localparam int STEP_BITS     = $clog2(SPEED_BITS);
  localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * SPEED_BITS + 7) / 8) * 8;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(1500);
  localparam logic [COUNT_BITS-1:0]  TIMEOUT_RESET   = COUNT_BITS'(4096);
  localparam logic [SPEED_BITS-1:0]  NUMERATOR_RESET = SPEED_BITS'(60 * 4000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_NUMERATOR = 2'd2
  } cfg_idx_e;

  // What the back end does to one channel's latched speed
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_ZERO = 2'd1,
    OP_DIV  = 2'd2
  } op_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] threshold;
    logic [COUNT_BITS-1:0]  timeout;
    logic [SPEED_BITS-1:0]  numerator;
  } cfg_t;

  typedef struct packed {
    op_e                   op;
    logic [COUNT_BITS-1:0] diff;
    logic                  finished;
  } chan_job_t;

  typedef struct packed {
    chan_job_t [1:0] chan;
    logic            done;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### hw/rtl/dtps_front.sv
// Front end: takes sample pairs, tracks per-channel counters and crossings,
// and queues one job per transfer. Depends on dtps_pkg.
`timescale 1ns / 1ps

module dtps_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dtps_pkg::cfg_t                          cfg_i,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic [1:0][dtps_pkg::SAMPLE_BITS-1:0]   samples_i,
  input  dtps_pkg::fifo_stat_t                    stat_i,
  output logic                                    push_o,
  output dtps_pkg::job_t                          job_o
);
  import dtps_pkg::*;

  logic [1:0][COUNT_BITS-1:0]  cnt_q, cnt_d, cnt_inc, first_n, diff;
  logic [1:0][COUNT_BITS-1:0]  first_q, first_d;
  logic [1:0][SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [1:0]                  fin_q, fin_d, fin_n, crossing, timeout, div_hit;
  logic                        done;

  assign ready_o = !stat_i.full;
  assign push_o  = valid_i && ready_o;

  // Per-channel step and job classification
  always_comb begin
    cnt_d   = cnt_q;
    first_d = first_q;
    prev_d  = prev_q;
    fin_n   = fin_q;
    job_o   = '0;
    for (int c = 0; c < 2; c++) begin
      cnt_inc[c]  = (cnt_q[c] != '1) ? cnt_q[c] + COUNT_BITS'(1) : cnt_q[c];
      crossing[c] = (samples_i[c] < cfg_i.threshold) && (prev_q[c] >= cfg_i.threshold);
      first_n[c]  = (crossing[c] && first_q[c] == '0) ? cnt_inc[c] : first_q[c];
      diff[c]     = cnt_inc[c] - first_n[c];
      timeout[c]  = cnt_inc[c] > cfg_i.timeout;
      div_hit[c]  = crossing[c] && (first_n[c] != '0) && (diff[c] > COUNT_BITS'(1));
      job_o.chan[c].op   = OP_HOLD;
      job_o.chan[c].diff = diff[c];
      if (!fin_q[c]) begin
        cnt_d[c]   = cnt_inc[c];
        first_d[c] = first_n[c];
        prev_d[c]  = samples_i[c];
        if (timeout[c]) begin
          job_o.chan[c].op = OP_ZERO;
          fin_n[c]         = 1'b1;
        end else if (div_hit[c]) begin
          job_o.chan[c].op = OP_DIV;
          fin_n[c]         = 1'b1;
        end
      end
      job_o.chan[c].finished = fin_n[c];
    end
    done       = fin_n[0] && fin_n[1];
    job_o.done = done;
    fin_d      = fin_n;
    // both channels done: start a fresh window
    if (done) begin
      cnt_d   = '0;
      first_d = '0;
      prev_d  = '0;
      fin_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= '0;
      prev_q  <= '0;
      fin_q   <= '0;
    end else if (push_o) begin
      cnt_q   <= cnt_d;
      first_q <= first_d;
      prev_q  <= prev_d;
      fin_q   <= fin_d;
    end
  end

endmodule

### hw/rtl/dtps_fifo.sv
// Short job queue between front and back ends.
// Depends on dtps_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "dual_tacho_period_speed_macros.svh"

module dtps_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dtps_pkg::job_t       job_i,
  input  logic                 pop_i,
  output dtps_pkg::job_t       job_o,
  output dtps_pkg::fifo_stat_t stat_o
);
  import dtps_pkg::*;

  job_t                  mem_q [JOB_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [LEVEL_BITS-1:0] level_q;

  assign stat_o.full  = (level_q == LEVEL_BITS'(JOB_DEPTH));
  assign stat_o.empty = (level_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + LEVEL_BITS'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - LEVEL_BITS'(1);
      end
    end
  end

  `DTPS_ASSERT_IMP(a_no_overflow, push_i, !stat_o.full || pop_i)
  `DTPS_ASSERT_IMP(a_no_underflow, pop_i, !stat_o.empty)
  `DTPS_ASSERT_IMP(a_level_bound, 1'b1, level_q <= LEVEL_BITS'(JOB_DEPTH))

endmodule

### hw/rtl/dtps_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on dtps_pkg.
`timescale 1ns / 1ps

module dtps_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [dtps_pkg::SPEED_BITS-1:0] dividend_i,
  input  logic [dtps_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                            done_o,
  output logic [dtps_pkg::SPEED_BITS-1:0] quotient_o
);
  import dtps_pkg::*;

  logic [COUNT_BITS-1:0] rem_q, rem_d, div_q;
  logic [SPEED_BITS-1:0] quo_q, quo_d;
  logic [STEP_BITS-1:0]  step_q;
  logic                  busy_q, done_q;
  logic [COUNT_BITS:0]   shifted, diff;
  logic                  fits;

  // One restoring step
  always_comb begin
    shifted = {rem_q, quo_q[SPEED_BITS-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
    rem_d   = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    quo_d   = {quo_q[SPEED_BITS-2:0], fits};
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        step_q <= step_q + STEP_BITS'(1);
        if (step_q == STEP_BITS'(SPEED_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/dtps_back.sv
// Back end: takes jobs from the queue, runs divisions, keeps the latched
// speeds and drives the result register. Depends on dtps_pkg, dtps_div, macros.
`timescale 1ns / 1ps
`include "dual_tacho_period_speed_macros.svh"

module dtps_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [dtps_pkg::SPEED_BITS-1:0]       numerator_i,
  input  dtps_pkg::fifo_stat_t                  stat_i,
  input  dtps_pkg::job_t                        job_i,
  output logic                                  pop_o,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [1:0][dtps_pkg::SPEED_BITS-1:0]  speeds_o,
  output logic [1:0]                            flags_o,
  output logic                                  last_o
);
  import dtps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e                     state_q;
  job_t                       job_q;
  logic                       ch_q;
  logic [1:0][SPEED_BITS-1:0] latched_q;
  logic                       div_start, div_done, emit;
  logic [SPEED_BITS-1:0]      quotient;

  assign pop_o     = (state_q == ST_IDLE) && !stat_i.empty;
  assign div_start = (state_q == ST_LOAD) && (job_q.chan[ch_q].op == OP_DIV);
  assign emit      = (state_q == ST_EMIT) && (!valid_o || ready_i);

  dtps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (numerator_i),
    .divisor_i  (job_q.chan[ch_q].diff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Job sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      job_q     <= '0;
      ch_q      <= 1'b0;
      latched_q <= '0;
      valid_o   <= 1'b0;
      speeds_o  <= '0;
      flags_o   <= '0;
      last_o    <= 1'b0;
    end else begin
      if (ready_i && !emit) begin
        valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            job_q   <= job_i;
            ch_q    <= 1'b0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          case (job_q.chan[ch_q].op)
            OP_DIV: begin
              state_q <= ST_WAIT;
            end
            OP_ZERO: begin
              latched_q[ch_q] <= '0;
              ch_q            <= 1'b1;
              state_q         <= ch_q ? ST_EMIT : ST_LOAD;
            end
            default: begin
              ch_q    <= 1'b1;
              state_q <= ch_q ? ST_EMIT : ST_LOAD;
            end
          endcase
        end
        ST_WAIT: begin
          if (div_done) begin
            latched_q[ch_q] <= quotient;
            ch_q            <= 1'b1;
            state_q         <= ch_q ? ST_EMIT : ST_LOAD;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            valid_o  <= 1'b1;
            speeds_o <= latched_q;
            flags_o  <= {job_q.chan[1].finished, job_q.chan[0].finished};
            last_o   <= job_q.done;
            // window closed: latched speeds start over
            if (job_q.done) begin
              latched_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `DTPS_ASSERT_IMP(a_done_has_both, valid_o && last_o, flags_o == 2'b11)
  `DTPS_ASSERT_IMP(a_div_done_waits, div_done, state_q == ST_WAIT)
  `DTPS_ASSERT_NXT(a_window_clears, emit && job_q.done, latched_q == '0)

endmodule

### hw/rtl/dual_tacho_period_speed.sv
// Dual tachometer period meter: one result per sample pair.
// A job passes from the front end through the job queue to the back-end sequencer,
// which steps through both channels, waits on the serial divider (one quotient bit per
// cycle) for each division and then registers the result. The sequencer takes a new job
// only when idle, so it and its shared divider set the pace; a 2-deep job queue decouples input.
// Reset (asynchronous, active low) clears all channel state and loads register defaults.
`timescale 1ns / 1ps

module dual_tacho_period_speed (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_a, sample_b
  input  logic [dtps_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // speed_a, speed_b
  output logic [dtps_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // speed_a_ready, speed_b_ready
  output logic [1:0]                           m_axis_tuser,
  // window_done
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [dtps_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [dtps_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import dtps_pkg::*;

  cfg_t                        cfg_q;
  logic [1:0][SAMPLE_BITS-1:0] samples;
  logic [1:0][SPEED_BITS-1:0]  speeds;
  job_t                        push_job, pop_job;
  fifo_stat_t                  stat;
  logic                        push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RESET;
      cfg_q.timeout   <= TIMEOUT_RESET;
      cfg_q.numerator <= NUMERATOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_TIMEOUT:   cfg_q.timeout   <= cfg_data_i[COUNT_BITS-1:0];
        CFG_NUMERATOR: cfg_q.numerator <= cfg_data_i[SPEED_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign samples[0] = s_axis_tdata[SAMPLE_BITS-1:0];
  assign samples[1] = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  dtps_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .samples_i (samples),
    .stat_i    (stat),
    .push_o    (push),
    .job_o     (push_job)
  );

  dtps_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (stat)
  );

  dtps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .numerator_i (cfg_q.numerator),
    .stat_i      (stat),
    .job_i       (pop_job),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .speeds_o    (speeds),
    .flags_o     (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_BITS'(speeds);

endmodule
